[hdl/sample_rate_autorange_macros.svh]
// Assertion macros for the sample-rate auto-ranging selector.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef SAMPLE_RATE_AUTORANGE_MACROS_SVH
`define SAMPLE_RATE_AUTORANGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sra_pkg.sv]
// Shared types, codes and constant tables for the sample-rate auto-ranging selector.
// Depends on nothing.
package sra_pkg;

    localparam int FREQ_W     = 21;
    localparam int CODE_W     = 2;
    localparam int RANGE_W    = 4;
    localparam int RELOAD_W   = 16;
    localparam int PRESCALE_W = 6;
    localparam int RATE_W     = 19;

    typedef logic [FREQ_W-1:0]     t_freq;
    typedef logic [CODE_W-1:0]     t_code;
    typedef logic [RANGE_W-1:0]    t_range;
    typedef logic [RELOAD_W-1:0]   t_reload;
    typedef logic [PRESCALE_W-1:0] t_prescale;
    typedef logic [RATE_W-1:0]     t_rate;

    // Change codes.
    localparam t_code CHG_NONE = 2'd0;
    localparam t_code CHG_STEP = 2'd1;
    localparam t_code CHG_JUMP = 2'd2;

    // Range indexes, fastest first.
    localparam t_range RNG_496K = 4'd0;
    localparam t_range RNG_320K = 4'd1;
    localparam t_range RNG_240K = 4'd2;
    localparam t_range RNG_160K = 4'd3;
    localparam t_range RNG_80K  = 4'd4;
    localparam t_range RNG_64K  = 4'd5;
    localparam t_range RNG_25K6 = 4'd6;
    localparam t_range RNG_12K8 = 4'd7;
    localparam t_range RNG_2K56 = 4'd8;
    localparam t_range RNG_1K28 = 4'd9;
    localparam t_range RNG_512  = 4'd10;
    localparam t_range RNG_LAST = RNG_512;

    localparam t_reload   RESET_RELOAD   = 16'd144;
    localparam t_prescale RESET_PRESCALE = 6'd1;

    // Nominal sample rate of each range, rounded to whole hertz.
    function automatic t_rate rate_of(input t_range rng);
        t_rate rate;
        case (rng)
            RNG_496K: rate = 19'd496552;
            RNG_320K: rate = 19'd320000;
            RNG_240K: rate = 19'd230769;
            RNG_160K: rate = 19'd159292;
            RNG_80K:  rate = 19'd80000;
            RNG_64K:  rate = 19'd64000;
            RNG_25K6: rate = 19'd25600;
            RNG_12K8: rate = 19'd12800;
            RNG_2K56: rate = 19'd2560;
            RNG_1K28: rate = 19'd1280;
            RNG_512:  rate = 19'd512;
            default:  rate = '0;
        endcase
        return rate;
    endfunction

endpackage

[hdl/sample_rate_autorange.sv]
// Sample-rate auto-ranging selector: input register, range decision, result register.
// Depends on sra_pkg and sample_rate_autorange_macros.svh.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_measured_freq
//  result   out        o_valid / i_stall   o_change_code, o_range_now, o_timer_reload,
//                                          o_timer_prescale, o_rate_hz
//
// Each transfer is held in the input register and then moves into the result register;
// one item per cycle is sustained while the result side does not stall.
// The range state updates as an item moves into the result register.
// Reset is synchronous and active low; it returns the block to the 496 kHz range.
// A stall on the result side holds the result register and, once the input register is
// also full, raises o_stall in the same cycle.
`include "sample_rate_autorange_macros.svh"

module sample_rate_autorange (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sra_pkg::FREQ_W-1:0]   i_measured_freq,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sra_pkg::CODE_W-1:0]     o_change_code,
    output logic [sra_pkg::RANGE_W-1:0]    o_range_now,
    output logic [sra_pkg::RELOAD_W-1:0]   o_timer_reload,
    output logic [sra_pkg::PRESCALE_W-1:0] o_timer_prescale,
    output logic [sra_pkg::RATE_W-1:0]     o_rate_hz
);

    logic               r_in_valid;
    sra_pkg::t_freq     r_in_freq;
    logic               r_out_valid;
    sra_pkg::t_code     r_code;
    sra_pkg::t_rate     r_rate;

    sra_pkg::t_range    r_range;
    sra_pkg::t_reload   r_reload;
    sra_pkg::t_prescale r_prescale;

    sra_pkg::t_range    n_range;
    sra_pkg::t_reload   n_reload;
    sra_pkg::t_prescale n_prescale;
    sra_pkg::t_code     n_code;

    logic advance;
    logic in_xfer;
    logic is_zero;
    sra_pkg::t_freq f;

    // The result register frees up when empty or when its content is taken this cycle.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    assign f       = r_in_freq;
    assign is_zero = (f == '0);

    always_comb begin
        n_range    = r_range;
        n_reload   = r_reload;
        n_prescale = r_prescale;
        n_code     = sra_pkg::CHG_NONE;
        case (r_range)
            sra_pkg::RNG_496K: begin
                if (!(f >= 21'd80000 && f <= 21'd1240000)) begin
                    n_range = sra_pkg::RNG_320K; n_reload = 16'd24; n_prescale = 6'd9;
                    n_code  = sra_pkg::CHG_STEP;
                end
            end
            sra_pkg::RNG_320K: begin
                if (!(f > 21'd50000 && f <= 21'd90000)) begin
                    if (f > 21'd90000) begin
                        n_range = sra_pkg::RNG_496K; n_reload = sra_pkg::RESET_RELOAD;
                        n_prescale = sra_pkg::RESET_PRESCALE; n_code = sra_pkg::CHG_STEP;
                    end else if (is_zero) begin
                        n_range = sra_pkg::RNG_80K; n_reload = 16'd24; n_prescale = 6'd36;
                        n_code  = sra_pkg::CHG_JUMP;
                    end else begin
                        n_range = sra_pkg::RNG_240K; n_reload = 16'd25; n_prescale = 6'd12;
                        n_code  = sra_pkg::CHG_STEP;
                    end
                end
            end
            sra_pkg::RNG_240K: begin
                if (!(f >= 21'd37500 && f <= 21'd80000)) begin
                    n_code = sra_pkg::CHG_STEP;
                    if (f > 21'd80000) begin
                        n_range = sra_pkg::RNG_320K; n_reload = 16'd24; n_prescale = 6'd9;
                    end else begin
                        n_range = sra_pkg::RNG_160K; n_reload = 16'd225; n_prescale = 6'd2;
                    end
                end
            end
            sra_pkg::RNG_160K: begin
                if (!(f >= 21'd20000 && f <= 21'd50000)) begin
                    n_code = sra_pkg::CHG_STEP;
                    if (f > 21'd50000) begin
                        n_range = sra_pkg::RNG_240K; n_reload = 16'd25; n_prescale = 6'd12;
                    end else begin
                        n_range = sra_pkg::RNG_80K; n_reload = 16'd24; n_prescale = 6'd36;
                    end
                end
            end
            sra_pkg::RNG_80K: begin
                if (!(f >= 21'd12500 && f <= 21'd25000)) begin
                    if (f > 21'd25000) begin
                        n_range = sra_pkg::RNG_160K; n_reload = 16'd225; n_prescale = 6'd2;
                        n_code  = sra_pkg::CHG_STEP;
                    end else if (is_zero) begin
                        // The zero jump loads the other 25.6 kHz reload.
                        n_range = sra_pkg::RNG_25K6; n_reload = 16'd79; n_prescale = 6'd36;
                        n_code  = sra_pkg::CHG_JUMP;
                    end else begin
                        n_range = sra_pkg::RNG_64K; n_reload = 16'd124; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_STEP;
                    end
                end
            end
            sra_pkg::RNG_64K: begin
                if (!(f > 21'd7500 && f <= 21'd20000)) begin
                    n_code = sra_pkg::CHG_STEP;
                    if (f > 21'd20000) begin
                        n_range = sra_pkg::RNG_80K; n_reload = 16'd24; n_prescale = 6'd36;
                    end else begin
                        n_range = sra_pkg::RNG_25K6; n_reload = 16'd77; n_prescale = 6'd36;
                    end
                end
            end
            sra_pkg::RNG_25K6: begin
                if (!(f > 21'd3500 && f <= 21'd8000)) begin
                    if (f > 21'd8000) begin
                        n_range = sra_pkg::RNG_64K; n_reload = 16'd124; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_STEP;
                    end else if (is_zero) begin
                        n_range = sra_pkg::RNG_2K56; n_reload = 16'd3124; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_JUMP;
                    end else begin
                        n_range = sra_pkg::RNG_12K8; n_reload = 16'd624; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_STEP;
                    end
                end
            end
            sra_pkg::RNG_12K8: begin
                if (!(f > 21'd800 && f <= 21'd4000)) begin
                    n_code = sra_pkg::CHG_STEP;
                    if (f > 21'd4000) begin
                        n_range = sra_pkg::RNG_25K6; n_reload = 16'd77; n_prescale = 6'd36;
                    end else begin
                        n_range = sra_pkg::RNG_2K56; n_reload = 16'd3124; n_prescale = 6'd9;
                    end
                end
            end
            sra_pkg::RNG_2K56: begin
                if (!(f >= 21'd390 && f <= 21'd800)) begin
                    if (f > 21'd800) begin
                        n_range = sra_pkg::RNG_12K8; n_reload = 16'd624; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_STEP;
                    end else if (is_zero) begin
                        n_range = sra_pkg::RNG_512; n_reload = 16'd15624; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_JUMP;
                    end else begin
                        n_range = sra_pkg::RNG_1K28; n_reload = 16'd6250; n_prescale = 6'd9;
                        n_code  = sra_pkg::CHG_STEP;
                    end
                end
            end
            sra_pkg::RNG_1K28: begin
                if (!(f >= 21'd50 && f <= 21'd400)) begin
                    n_code = sra_pkg::CHG_STEP;
                    if (f > 21'd400) begin
                        n_range = sra_pkg::RNG_2K56; n_reload = 16'd3124; n_prescale = 6'd9;
                    end else begin
                        n_range = sra_pkg::RNG_512; n_reload = 16'd15624; n_prescale = 6'd9;
                    end
                end
            end
            sra_pkg::RNG_512: begin
                // Leaving the slowest range always wraps to the fastest.
                if (!(f >= 21'd9 && f <= 21'd40)) begin
                    n_range = sra_pkg::RNG_496K; n_reload = sra_pkg::RESET_RELOAD;
                    n_prescale = sra_pkg::RESET_PRESCALE; n_code = sra_pkg::CHG_STEP;
                end
            end
            default: begin
                n_range = sra_pkg::RNG_496K; n_reload = sra_pkg::RESET_RELOAD;
                n_prescale = sra_pkg::RESET_PRESCALE; n_code = sra_pkg::CHG_STEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_range     <= sra_pkg::RNG_496K;
            r_reload    <= sra_pkg::RESET_RELOAD;
            r_prescale  <= sra_pkg::RESET_PRESCALE;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_range     <= n_range;
                r_reload    <= n_reload;
                r_prescale  <= n_prescale;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_freq <= i_measured_freq;
        end
        if (advance) begin
            r_code <= n_code;
            r_rate <= sra_pkg::rate_of(n_range);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_change_code    = r_code;
    assign o_range_now      = r_range;
    assign o_timer_reload   = r_reload;
    assign o_timer_prescale = r_prescale;
    assign o_rate_hz        = r_rate;

    `SRA_ASSERT_NOW(a_range_legal, 1'b1, r_range <= sra_pkg::RNG_LAST, "range index out of table")
    `SRA_ASSERT_NOW(a_jump_target, r_out_valid && r_code == sra_pkg::CHG_JUMP,
        r_range == sra_pkg::RNG_80K || r_range == sra_pkg::RNG_25K6 || r_range == sra_pkg::RNG_2K56 || r_range == sra_pkg::RNG_512,
        "zero jump landed on an unexpected range")
    `SRA_ASSERT_NEXT(a_state_holds, !advance, $stable(r_range) && $stable(r_reload),
        "range state changed without a transfer")
    `SRA_ASSERT_NEXT(a_in_captured, in_xfer, r_in_valid, "accepted item not held in input register")

endmodule

[tb/sv/sra_range_checker.sv]
// Result checker for the sample-rate auto-ranging selector: watches both channels,
// predicts each result from its own copy of the range state and compares field by field.
// Depends on sra_pkg for the field types, change codes and range indexes.
module sra_range_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_freq_valid,
    input  logic               i_freq_stall,
    input  sra_pkg::t_freq     i_measured_freq,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  sra_pkg::t_code     i_change_code,
    input  sra_pkg::t_range    i_range_now,
    input  sra_pkg::t_reload   i_timer_reload,
    input  sra_pkg::t_prescale i_timer_prescale,
    input  sra_pkg::t_rate     i_rate_hz,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sra_pkg::t_code     code;
        sra_pkg::t_range    rng;
        sra_pkg::t_reload   reload;
        sra_pkg::t_prescale prescale;
        sra_pkg::t_rate     rate;
    } t_range_setting;

    t_range_setting setting_now;
    t_range_setting expected_q[$];
    int             fail_total = 0;

    function automatic sra_pkg::t_rate nominal_rate(input sra_pkg::t_range rng);
        case (rng)
            sra_pkg::RNG_496K: return 19'd496552;
            sra_pkg::RNG_320K: return 19'd320000;
            sra_pkg::RNG_240K: return 19'd230769;
            sra_pkg::RNG_160K: return 19'd159292;
            sra_pkg::RNG_80K:  return 19'd80000;
            sra_pkg::RNG_64K:  return 19'd64000;
            sra_pkg::RNG_25K6: return 19'd25600;
            sra_pkg::RNG_12K8: return 19'd12800;
            sra_pkg::RNG_2K56: return 19'd2560;
            sra_pkg::RNG_1K28: return 19'd1280;
            sra_pkg::RNG_512:  return 19'd512;
            default:           return '0;
        endcase
    endfunction

    function automatic t_range_setting land(input sra_pkg::t_range rng,
                                            input sra_pkg::t_reload reload,
                                            input sra_pkg::t_prescale prescale,
                                            input sra_pkg::t_code code);
        t_range_setting s;
        s.code     = code;
        s.rng      = rng;
        s.reload   = reload;
        s.prescale = prescale;
        s.rate     = nominal_rate(rng);
        return s;
    endfunction

    // Next range setting for one measured frequency (tenths of hertz).
    function automatic t_range_setting next_setting(input t_range_setting cur,
                                                    input sra_pkg::t_freq f);
        t_range_setting s;
        s = land(cur.rng, cur.reload, cur.prescale, sra_pkg::CHG_NONE);
        case (cur.rng)
            sra_pkg::RNG_496K:
                if (!(f >= 80000 && f <= 1240000))
                    s = land(sra_pkg::RNG_320K, 16'd24, 6'd9, sra_pkg::CHG_STEP);
            sra_pkg::RNG_320K:
                if (!(f > 50000 && f <= 90000)) begin
                    if (f > 90000)
                        s = land(sra_pkg::RNG_496K, sra_pkg::RESET_RELOAD,
                                 sra_pkg::RESET_PRESCALE, sra_pkg::CHG_STEP);
                    else if (f == 0)
                        s = land(sra_pkg::RNG_80K, 16'd24, 6'd36, sra_pkg::CHG_JUMP);
                    else
                        s = land(sra_pkg::RNG_240K, 16'd25, 6'd12, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_240K:
                if (!(f >= 37500 && f <= 80000)) begin
                    if (f > 80000)
                        s = land(sra_pkg::RNG_320K, 16'd24, 6'd9, sra_pkg::CHG_STEP);
                    else
                        s = land(sra_pkg::RNG_160K, 16'd225, 6'd2, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_160K:
                if (!(f >= 20000 && f <= 50000)) begin
                    if (f > 50000)
                        s = land(sra_pkg::RNG_240K, 16'd25, 6'd12, sra_pkg::CHG_STEP);
                    else
                        s = land(sra_pkg::RNG_80K, 16'd24, 6'd36, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_80K:
                if (!(f >= 12500 && f <= 25000)) begin
                    // The zero jump into 25.6 kHz loads a different reload from the step.
                    if (f > 25000)
                        s = land(sra_pkg::RNG_160K, 16'd225, 6'd2, sra_pkg::CHG_STEP);
                    else if (f == 0)
                        s = land(sra_pkg::RNG_25K6, 16'd79, 6'd36, sra_pkg::CHG_JUMP);
                    else
                        s = land(sra_pkg::RNG_64K, 16'd124, 6'd9, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_64K:
                if (!(f > 7500 && f <= 20000)) begin
                    if (f > 20000)
                        s = land(sra_pkg::RNG_80K, 16'd24, 6'd36, sra_pkg::CHG_STEP);
                    else
                        s = land(sra_pkg::RNG_25K6, 16'd77, 6'd36, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_25K6:
                if (!(f > 3500 && f <= 8000)) begin
                    if (f > 8000)
                        s = land(sra_pkg::RNG_64K, 16'd124, 6'd9, sra_pkg::CHG_STEP);
                    else if (f == 0)
                        s = land(sra_pkg::RNG_2K56, 16'd3124, 6'd9, sra_pkg::CHG_JUMP);
                    else
                        s = land(sra_pkg::RNG_12K8, 16'd624, 6'd9, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_12K8:
                if (!(f > 800 && f <= 4000)) begin
                    if (f > 4000)
                        s = land(sra_pkg::RNG_25K6, 16'd77, 6'd36, sra_pkg::CHG_STEP);
                    else
                        s = land(sra_pkg::RNG_2K56, 16'd3124, 6'd9, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_2K56:
                if (!(f >= 390 && f <= 800)) begin
                    if (f > 800)
                        s = land(sra_pkg::RNG_12K8, 16'd624, 6'd9, sra_pkg::CHG_STEP);
                    else if (f == 0)
                        s = land(sra_pkg::RNG_512, 16'd15624, 6'd9, sra_pkg::CHG_JUMP);
                    else
                        s = land(sra_pkg::RNG_1K28, 16'd6250, 6'd9, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_1K28:
                if (!(f >= 50 && f <= 400)) begin
                    if (f > 400)
                        s = land(sra_pkg::RNG_2K56, 16'd3124, 6'd9, sra_pkg::CHG_STEP);
                    else
                        s = land(sra_pkg::RNG_512, 16'd15624, 6'd9, sra_pkg::CHG_STEP);
                end
            sra_pkg::RNG_512:
                // Leaving the slowest range in either direction wraps to the fastest.
                if (!(f >= 9 && f <= 40))
                    s = land(sra_pkg::RNG_496K, sra_pkg::RESET_RELOAD,
                             sra_pkg::RESET_PRESCALE, sra_pkg::CHG_STEP);
            default:
                s = land(sra_pkg::RNG_496K, sra_pkg::RESET_RELOAD,
                         sra_pkg::RESET_PRESCALE, sra_pkg::CHG_STEP);
        endcase
        return s;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $error("%s: expected %0d, got %0d", field, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_range_setting want;
        if (!i_rst_n) begin
            setting_now = land(sra_pkg::RNG_496K, sra_pkg::RESET_RELOAD,
                               sra_pkg::RESET_PRESCALE, sra_pkg::CHG_NONE);
            expected_q.delete();
        end else begin
            // The result side is handled first: a result can never belong to an
            // input transfer of the same cycle.
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_change_code !== want.code)
                        note_mismatch("change_code", want.code, i_change_code);
                    if (i_range_now !== want.rng)
                        note_mismatch("range_now", want.rng, i_range_now);
                    if (i_timer_reload !== want.reload)
                        note_mismatch("timer_reload", want.reload, i_timer_reload);
                    if (i_timer_prescale !== want.prescale)
                        note_mismatch("timer_prescale", want.prescale, i_timer_prescale);
                    if (i_rate_hz !== want.rate)
                        note_mismatch("rate_hz", want.rate, i_rate_hz);
                end
            end
            if (i_freq_valid && !i_freq_stall) begin
                setting_now = next_setting(setting_now, i_measured_freq);
                expected_q.push_back(setting_now);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/sv/sample_rate_autorange_test.sv]
// Top of the sample-rate auto-ranging selector testbench: clock, reset, frequency stimulus,
// random idle gaps on the input, random stalls on the result channel, watchdog and verdict.
// Depends on sra_pkg, sample_rate_autorange and sra_range_checker.
module sample_rate_autorange_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS   = 900;
    localparam int IDLE_PERCENT   = 38;
    localparam int CALM_FROM      = 300;
    localparam int CALM_TO        = 450;
    localparam int QUIET_LIMIT    = 1000;
    localparam int FREQ_MAX       = 2000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    sra_pkg::t_freq     i_measured_freq = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    sra_pkg::t_code     o_change_code;
    sra_pkg::t_range    o_range_now;
    sra_pkg::t_reload   o_timer_reload;
    sra_pkg::t_prescale o_timer_prescale;
    sra_pkg::t_rate     o_rate_hz;

    int fail_count;
    int pending;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sample_rate_autorange i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_measured_freq  (i_measured_freq),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_change_code    (o_change_code),
        .o_range_now      (o_range_now),
        .o_timer_reload   (o_timer_reload),
        .o_timer_prescale (o_timer_prescale),
        .o_rate_hz        (o_rate_hz)
    );

    sra_range_checker u_range_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_freq_valid     (i_valid),
        .i_freq_stall     (o_stall),
        .i_measured_freq  (i_measured_freq),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_change_code    (o_change_code),
        .i_range_now      (o_range_now),
        .i_timer_reload   (o_timer_reload),
        .i_timer_prescale (o_timer_prescale),
        .i_rate_hz        (o_rate_hz),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Walks down through every range, with some steps back up, across window edges and zero cases.
    function automatic sra_pkg::t_freq directed_freq(input int k);
        case (k)
            0:  return 1240000;
            1:  return 80000;
            2:  return 0;
            3:  return 90001;
            4:  return 21'h1FFFFF;
            5:  return 0;
            6:  return 0;
            7:  return 0;
            8:  return 0;
            9:  return 9;
            10: return 41;
            11: return 50000;
            12: return 50000;
            13: return 0;
            14: return 0;
            15: return 12499;
            16: return 0;
            17: return 8001;
            18: return 7500;
            19: return 3500;
            20: return 0;
            21: return 801;
            22: return 800;
            23: return 389;
            24: return 0;
            default: return 8;
        endcase
    endfunction

    function automatic int window_edge(input int pick);
        case (pick)
            0:  return 1240000;
            1:  return 80000;
            2:  return 90000;
            3:  return 50000;
            4:  return 37500;
            5:  return 20000;
            6:  return 25000;
            7:  return 12500;
            8:  return 7500;
            9:  return 8000;
            10: return 3500;
            11: return 4000;
            12: return 800;
            13: return 390;
            14: return 400;
            15: return 50;
            16: return 40;
            default: return 9;
        endcase
    endfunction

    function automatic sra_pkg::t_freq noise_freq();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return sra_pkg::t_freq'(window_edge($urandom_range(0, 17))
                                    + $urandom_range(0, 2) - 1);
        else if (pick < 60)
            return '0;
        else if (pick < 90)
            return sra_pkg::t_freq'($urandom_range(0, FREQ_MAX));
        else
            return sra_pkg::t_freq'($urandom);
    endfunction

    // One transfer on the input channel; entered and left at a falling edge.
    task automatic send_freq(input sra_pkg::t_freq f);
        calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_measured_freq <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // A slowly gliding frequency with jitter, so that the block tracks it range by range.
    task automatic sweep_freq(input real from_f, input real to_f, input int steps);
        real ratio;
        real f;
        real v;
        ratio = $pow(to_f / from_f, 1.0 / steps);
        f = from_f;
        repeat (steps) begin
            v = f * (0.9 + 0.2 * $urandom_range(0, 1000) / 1000.0);
            if (v > FREQ_MAX) v = FREQ_MAX;
            send_freq(sra_pkg::t_freq'($rtoi(v)));
            f = f * ratio;
        end
    endtask

    initial begin
        int pick;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < DIRECTED_ITEMS; k++)
            send_freq(directed_freq(k));
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                sweep_freq($urandom_range(900000, 1240000), $urandom_range(9, 30),
                           $urandom_range(30, 70));
            else if (pick < 60)
                sweep_freq($urandom_range(9, 2000), $urandom_range(100000, 1240000),
                           $urandom_range(30, 70));
            else
                repeat ($urandom_range(5, 20)) send_freq(noise_freq());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
